/* rtl/lrn_across_channels_unit_defines.svh */
// ----------------------------------------------------------------------------
// LRN assertion macros
// Shared concurrent assertion forms for the cross-channel LRN block.
// ----------------------------------------------------------------------------
`ifndef LRN_ACROSS_CHANNELS_UNIT_DEFINES_SVH
`define LRN_ACROSS_CHANNELS_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LRN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lrn_pkg.sv */
// ----------------------------------------------------------------------------
// LRN package
// Types, register codes and constant tables of the cross-channel LRN block.
// ----------------------------------------------------------------------------
package lrn_pkg;

    localparam int MAX_PLANE_DEF    = 4096;
    localparam int MAX_WINDOW_DEF   = 7;
    localparam int MAX_CHANNELS_DEF = 1024;

    localparam int LS_W       = 3;
    localparam int ALPHA_W    = 24;
    localparam int BETA_W     = 16;
    localparam int PSIZE_W    = 13;
    localparam int CTOT_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_SIZE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_TOTAL = 3'd4;

    localparam logic [LS_W-1:0]    RST_LOCAL_SIZE    = 3'd5;
    localparam logic [ALPHA_W-1:0] RST_ALPHA         = 24'd336;
    localparam logic [BETA_W-1:0]  RST_BETA          = 16'd12288;
    localparam logic [PSIZE_W-1:0] RST_PLANE_SIZE    = 13'd4096;
    localparam logic [CTOT_W-1:0]  RST_CHANNEL_TOTAL = 11'd96;

    typedef struct packed {
        logic        operation;
        logic [15:0] sample_value;
    } t_lrn_in;

    typedef struct packed {
        logic [15:0] normalized_value;
        logic        map_last;
    } t_lrn_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_RDL,
        S_UPD,
        S_RDC,
        S_PROD,
        S_NORM,
        S_LOG,
        S_TMUL,
        S_EXP,
        S_SHIFT,
        S_RES,
        S_OUT,
        S_ADV
    } t_lrn_state;

    typedef logic [15:0][31:0] t_exp_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        x = v;
        b = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Entry i holds 2^-(2^-(i+1)) in Q0.32, each the root of the one before.
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [63:0] c;
        c = 64'h0000_0000_8000_0000;
        for (int i = 0; i < 16; i++) begin
            c = isqrt64(c << 32);
            tab[i] = c[31:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

/* rtl/lrn_across_channels_unit.sv */
// ----------------------------------------------------------------------------
// Cross-channel LRN unit
// Normalizes a channel-major feature map across a window of channels.
// ----------------------------------------------------------------------------
// Usage: samples enter on the input channel (i_in_valid, o_in_stall), all
// pixels of channel 0 first, then channel 1 and so on; after the real
// channels the source sends pad drain beats that stand for zero channels.
// Each input beat gives at most one output beat on (o_out_valid, i_out_stall);
// the first pad_eff planes give none; map_last marks a map's final output.
// Registers are to be written on the configuration channel only while the
// unit is idle; the unit itself does not enforce this. An item runs the
// channel remainder over all W bits of the channel counter (11 at the default
// sizes), updates the sum, and for an output takes log2 and exp2 in 16
// iterations each of one multiplier step. The two single-port memories see
// up to three sample and two sum accesses per item. The next item can be
// accepted as soon as the result sits in the output register, even while
// the receiver stalls it; a stalled output holds and the unit waits only if
// a new result would overwrite it.
// Reset clears the counters and restores the register defaults; the sample
// and sum memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`include "lrn_across_channels_unit_defines.svh"

module lrn_across_channels_unit #(
    parameter int MAX_PLANE    = lrn_pkg::MAX_PLANE_DEF,
    parameter int MAX_WINDOW   = lrn_pkg::MAX_WINDOW_DEF,
    parameter int MAX_CHANNELS = lrn_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  lrn_pkg::t_lrn_in                i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output lrn_pkg::t_lrn_out               o_out_data,
    input  logic                            i_out_stall,
    input  logic                            i_cfg_valid,
    input  logic [lrn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lrn_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_cfg_ready
);
    import lrn_pkg::*;

    localparam int PW    = (MAX_PLANE > 1) ? $clog2(MAX_PLANE) : 1;
    localparam int PCW   = $clog2(MAX_PLANE + 1);
    localparam int CCW   = $clog2(MAX_CHANNELS + 1);
    localparam int VW    = $clog2(MAX_CHANNELS + MAX_WINDOW);
    localparam int VEW   = $clog2(MAX_CHANNELS + MAX_WINDOW + 1);
    localparam int DEPTH = MAX_WINDOW * MAX_PLANE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW   = ($clog2(VW) > 4) ? $clog2(VW) : 4;

    t_lrn_state r_state;
    t_lrn_state n_state;

    logic [LS_W-1:0]    r_cfg_ls;
    logic [ALPHA_W-1:0] r_cfg_alpha;
    logic [BETA_W-1:0]  r_cfg_beta;
    logic [PSIZE_W-1:0] r_cfg_psize;
    logic [CTOT_W-1:0]  r_cfg_ctot;

    logic [PW-1:0]   r_pos;
    logic [VW-1:0]   r_vch;
    logic [15:0]     r_x;
    logic [VW-1:0]   r_diva;
    logic [VW-1:0]   r_divb;
    logic [LS_W-1:0] r_rema;
    logic [LS_W-1:0] r_remb;
    logic [CNW-1:0]  r_step;
    logic [32:0]     r_sum;
    logic [15:0]     r_xs;
    logic [32:0]     r_prod;
    logic [31:0]     r_m;
    logic [3:0]      r_e;
    logic [15:0]     r_frac;
    logic [21:0]     r_t;
    logic [32:0]     r_r;
    logic [32:0]     r_factor;
    logic [15:0]     r_res;
    logic            r_out_valid;
    t_lrn_out        r_out_data;

    logic [15:0] mem_pw [DEPTH];
    logic [32:0] mem_sum [MAX_PLANE];
    logic [15:0] r_pw_rdata;
    logic [32:0] r_sum_rdata;

    logic [LS_W-1:0] l_eff;
    logic [LS_W-2:0] pad_eff;
    logic [PCW-1:0]  p_eff;
    logic [CCW-1:0]  c_eff;
    logic [VEW-1:0]  vend;

    logic            in_accept;
    logic            out_free;
    logic            pw_we;
    logic            sum_we;
    logic [AW-1:0]   pw_addr;
    logic [AW-1:0]   addr_a;
    logic [AW-1:0]   addr_b;
    logic            map_last;
    logic            wrap_pos;
    logic            wrap_vch;

    logic [PW-1:0]   pos_w;
    logic [VW-1:0]   vch_w;
    logic [LS_W:0]   ta;
    logic [LS_W:0]   tb;
    logic [15:0]     leaving;
    logic [15:0]     mag_x;
    logic [15:0]     mag_lv;
    logic [15:0]     mag_xs;
    logic [32:0]     sum_old;
    logic [32:0]     sum_new;
    logic [33:0]     scale_w;
    logic [31:0]     scale;
    logic [4:0]      top;
    logic [31:0]     m_init;
    logic [31:0]     m_sq;
    logic [15:0]     f_sh;
    logic [5:0]      t_int;
    logic [16:0]     res_mag;

    // Effective register values after clamping.
    always_comb begin
        if (r_cfg_ls == '0) begin
            l_eff = LS_W'(1);
        end else if (int'(r_cfg_ls) > MAX_WINDOW) begin
            l_eff = LS_W'(MAX_WINDOW);
        end else begin
            l_eff = r_cfg_ls;
        end
        pad_eff = (LS_W-1)'((l_eff - LS_W'(1)) >> 1);
        if (r_cfg_psize == '0) begin
            p_eff = PCW'(1);
        end else if (int'(r_cfg_psize) > MAX_PLANE) begin
            p_eff = PCW'(MAX_PLANE);
        end else begin
            p_eff = PCW'(r_cfg_psize);
        end
        if (r_cfg_ctot == '0) begin
            c_eff = CCW'(1);
        end else if (int'(r_cfg_ctot) > MAX_CHANNELS) begin
            c_eff = CCW'(MAX_CHANNELS);
        end else begin
            c_eff = CCW'(r_cfg_ctot);
        end
        vend = VEW'(c_eff) + VEW'(pad_eff);
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pos_w     = (PCW'(r_pos) >= p_eff) ? '0 : r_pos;
    assign vch_w     = (VEW'(r_vch) >= vend) ? '0 : r_vch;
    assign addr_a    = AW'(int'(r_rema) * MAX_PLANE + int'(r_pos));
    assign addr_b    = AW'(int'(r_remb) * MAX_PLANE + int'(r_pos));
    assign map_last  = (VEW'(r_vch) == vend - VEW'(1)) && (PCW'(r_pos) == p_eff - PCW'(1));
    assign wrap_pos  = (PCW'(r_pos) + PCW'(1)) >= p_eff;
    assign wrap_vch  = (VEW'(r_vch) + VEW'(1)) >= vend;

    // Datapath arithmetic.
    always_comb begin
        ta      = {r_rema, r_diva[VW-1]};
        tb      = {r_remb, r_divb[VW-1]};
        leaving = (int'(r_vch) >= int'(l_eff)) ? r_pw_rdata : 16'd0;
        mag_x   = r_x[15] ? (~r_x + 16'd1) : r_x;
        mag_lv  = leaving[15] ? (~leaving + 16'd1) : leaving;
        mag_xs  = r_xs[15] ? (~r_xs + 16'd1) : r_xs;
        sum_old = (r_vch == '0) ? 33'd0 : r_sum_rdata;
        sum_new = sum_old + 33'(32'(mag_x) * 32'(mag_x)) - 33'(32'(mag_lv) * 32'(mag_lv));
        scale_w = 34'h0_0001_0000 + 34'(r_prod);
        scale   = scale_w[33:32] != 2'd0 ? 32'hFFFF_FFFF : scale_w[31:0];
        top     = 5'd16;
        for (int k = 17; k < 32; k++) begin
            if (scale[k]) begin
                top = 5'(k);
            end
        end
        m_init  = (top == 5'd31) ? (scale >> 1) : (scale << (5'd30 - top));
        m_sq    = 32'((64'(r_m) * 64'(r_m)) >> 30);
        f_sh    = r_t[15:0] << r_step[3:0];
        t_int   = r_t[21:16];
        res_mag = 17'(((49'(mag_xs) * 49'(r_factor)) + 49'h0_8000_0000) >> 32);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (r_step == CNW'(VW - 1)) begin
                    n_state = S_RDL;
                end
            end
            S_RDL:   n_state = S_UPD;
            S_UPD: begin
                if (int'(r_vch) >= int'(pad_eff)) begin
                    n_state = S_RDC;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_RDC:   n_state = S_PROD;
            S_PROD:  n_state = S_NORM;
            S_NORM:  n_state = S_LOG;
            S_LOG: begin
                if (r_step == CNW'(15)) begin
                    n_state = S_TMUL;
                end
            end
            S_TMUL:  n_state = S_EXP;
            S_EXP: begin
                if (r_step == CNW'(15)) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: n_state = S_RES;
            S_RES:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ADV:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_in_stall = 1'b1;
        pw_we      = 1'b0;
        sum_we     = 1'b0;
        pw_addr    = addr_a;
        case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_UPD: begin
                pw_we  = 1'b1;
                sum_we = 1'b1;
            end
            S_RDC:  pw_addr = addr_b;
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (pw_we) begin
            mem_pw[pw_addr] <= r_x;
        end
        r_pw_rdata <= mem_pw[pw_addr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            mem_sum[r_pos] <= sum_new;
        end
        r_sum_rdata <= mem_sum[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_ls    <= RST_LOCAL_SIZE;
            r_cfg_alpha <= RST_ALPHA;
            r_cfg_beta  <= RST_BETA;
            r_cfg_psize <= RST_PLANE_SIZE;
            r_cfg_ctot  <= RST_CHANNEL_TOTAL;
            r_pos       <= '0;
            r_vch       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LOCAL_SIZE:    r_cfg_ls    <= i_cfg_data[LS_W-1:0];
                    CFG_ALPHA:         r_cfg_alpha <= i_cfg_data[ALPHA_W-1:0];
                    CFG_BETA:          r_cfg_beta  <= i_cfg_data[BETA_W-1:0];
                    CFG_PLANE_SIZE:    r_cfg_psize <= i_cfg_data[PSIZE_W-1:0];
                    CFG_CHANNEL_TOTAL: r_cfg_ctot  <= i_cfg_data[CTOT_W-1:0];
                    default: begin
                        r_cfg_ls <= r_cfg_ls;
                    end
                endcase
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_pos <= pos_w;
                        r_vch <= vch_w;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        if (wrap_pos) begin
                            r_pos <= '0;
                            r_vch <= wrap_vch ? '0 : r_vch + VW'(1);
                        end else begin
                            r_pos <= r_pos + PW'(1);
                        end
                    end
                end
                S_ADV: begin
                    if (wrap_pos) begin
                        r_pos <= '0;
                        r_vch <= wrap_vch ? '0 : r_vch + VW'(1);
                    end else begin
                        r_pos <= r_pos + PW'(1);
                    end
                end
                default: begin
                    r_pos <= r_pos;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x    <= i_in_data.operation ? 16'd0 : i_in_data.sample_value;
                r_diva <= vch_w;
                r_divb <= vch_w - VW'(pad_eff);
                r_rema <= '0;
                r_remb <= '0;
                r_step <= '0;
            end
            S_MOD: begin
                r_rema <= (ta >= (LS_W+1)'(l_eff)) ? LS_W'(ta - (LS_W+1)'(l_eff)) : LS_W'(ta);
                r_remb <= (tb >= (LS_W+1)'(l_eff)) ? LS_W'(tb - (LS_W+1)'(l_eff)) : LS_W'(tb);
                r_diva <= r_diva << 1;
                r_divb <= r_divb << 1;
                r_step <= (r_step == CNW'(VW - 1)) ? '0 : r_step + CNW'(1);
            end
            S_UPD: begin
                r_sum <= sum_new;
            end
            S_PROD: begin
                r_xs   <= r_pw_rdata;
                r_prod <= 33'((57'(r_cfg_alpha) * 57'(r_sum)) >> 24);
            end
            S_NORM: begin
                r_e    <= 4'(top - 5'd16);
                r_m    <= m_init;
                r_frac <= '0;
                r_step <= '0;
            end
            S_LOG: begin
                if (m_sq[31]) begin
                    r_frac <= {r_frac[14:0], 1'b1};
                    r_m    <= m_sq >> 1;
                end else begin
                    r_frac <= {r_frac[14:0], 1'b0};
                    r_m    <= m_sq;
                end
                r_step <= r_step + CNW'(1);
            end
            S_TMUL: begin
                r_t    <= 22'((36'(r_cfg_beta) * 36'({r_e, r_frac})) >> 14);
                r_r    <= 33'h1_0000_0000;
                r_step <= '0;
            end
            S_EXP: begin
                if (f_sh[15]) begin
                    r_r <= 33'((65'(r_r) * 65'(EXP_TAB[r_step[3:0]])) >> 32);
                end
                r_step <= r_step + CNW'(1);
            end
            S_SHIFT: begin
                r_factor <= (t_int >= 6'd33) ? 33'd0 : (r_r >> t_int);
            end
            S_RES: begin
                r_res <= r_xs[15] ? (16'd0 - res_mag[15:0]) : res_mag[15:0];
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_data.normalized_value <= r_res;
                    r_out_data.map_last         <= map_last;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    `LRN_ASSERT_NEXT(a_accept_starts_item, i_clk, i_rst_n, in_accept, r_state == S_MOD, "accepted beat did not start the remainder step")
    `LRN_ASSERT_NEXT(a_held_result_waits, i_clk, i_rst_n, (r_state == S_OUT) && r_out_valid && i_out_stall, (r_state == S_OUT) && r_out_valid, "new result overwrote a stalled output")
    `LRN_ASSERT_SAME(a_slot_in_window, i_clk, i_rst_n, r_state == S_RDL, r_rema < l_eff, "window slot outside the window")
    `LRN_ASSERT_NEXT(a_map_end_clears, i_clk, i_rst_n, (r_state == S_OUT) && out_free && map_last, (r_pos == '0) && (r_vch == '0), "counters not cleared after the last output of a map")

endmodule
